>>> sv/sts_pkg.sv
// Package with shared types, constants and the camera mask function of the strobe timer.
package sts_pkg;

  localparam int CAMERAS = 4;
  localparam int STROBE_BITS = 4;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS = 18;

  localparam logic [17:0] BEAT_PERIOD_RESET = 18'd250000;
  localparam logic [9:0] SHORT_WIDTH_RESET = 10'd8;
  localparam logic [9:0] LONG_WIDTH_RESET = 10'd256;
  localparam logic [7:0] SAMPLE_DELAY_RESET = 8'd16;
  localparam logic [7:0] STROBE_WIDTH_RESET = 8'd64;
  localparam logic [7:0] RATE_CODES_RESET = 8'd0;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_BEAT_PERIOD  = 3'd0,
    REG_SHORT_WIDTH  = 3'd1,
    REG_LONG_WIDTH   = 3'd2,
    REG_SAMPLE_DELAY = 3'd3,
    REG_STROBE_WIDTH = 3'd4,
    REG_RATE_CODES   = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic                   trigger_pulse;
    logic [STROBE_BITS-1:0] camera_strobes;
  } result_t;

  // Camera i fires when the beat count is a multiple of 8 >> code_i.
  function automatic logic [STROBE_BITS-1:0] next_mask(
    input logic [7:0] beats,
    input logic [7:0] codes
  );
    logic [STROBE_BITS-1:0] m;
    logic [1:0]             code;
    logic [2:0]             low_mask;
    m = '0;
    for (int i = 0; i < STROBE_BITS; i++) begin
      code = codes[2*i +: 2];
      low_mask = 3'd7 >> code;
      if ((i < CAMERAS) && ((beats[2:0] & low_mask) == 3'd0)) begin
        m[i] = 1'b1;
      end
    end
    return m;
  endfunction

endpackage

>>> sv/sts_if.sv
// Channel interfaces for the trigger input and the result output.
interface sts_in_if;
  logic valid;
  logic ready;
  logic trig_line;

  modport source (output valid, output trig_line, input ready);
  modport sink (input valid, input trig_line, output ready);
endinterface

interface sts_out_if;
  logic       valid;
  logic       ready;
  logic       trigger_pulse;
  logic [3:0] camera_strobes;

  modport source (output valid, output trigger_pulse, output camera_strobes, input ready);
  modport sink (input valid, input trigger_pulse, input camera_strobes, output ready);
endinterface

>>> sv/sync_trigger_strobe_timer.sv
// Top level of the synchronized trigger generator and camera strobe timer.
//   port     direction  contents
//   item     sink       trig_line, one base tick per transfer
//   result   source     trigger_pulse, camera_strobes, one per tick
//   cfg_*    write      six registers by index
// Each accepted tick is processed combinationally; a new tick can be taken every
// cycle while the buffer has space; results wait in a two-entry output buffer.
// The input stalls only when both buffer entries wait on the sink.
// Synchronous reset restores the register defaults and clears all counters.
module sync_trigger_strobe_timer (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [sts_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [sts_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  sts_in_if.sink                             item,
  sts_out_if.source                          result
);
  import sts_pkg::*;

  result_t step_result;
  result_t buf_data;
  logic    space;
  logic    tick;

  assign item.ready = space;
  assign tick = item.valid && space;

  sts_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .tick       (tick),
    .trig_line  (item.trig_line),
    .result     (step_result)
  );

  sts_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (tick),
    .push_data (step_result),
    .space     (space),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_data  (buf_data)
  );

  assign result.trigger_pulse = buf_data.trigger_pulse;
  assign result.camera_strobes = buf_data.camera_strobes;

endmodule

>>> sv/sts_core.sv
// Tick logic: configuration registers, pulse generator, edge receiver and strobe timer.
module sts_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [sts_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [sts_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  input  logic                                 tick,
  input  logic                                 trig_line,
  output sts_pkg::result_t                     result
);
  import sts_pkg::*;

  logic [17:0] beat_period;
  logic [9:0]  short_width;
  logic [9:0]  long_width;
  logic [7:0]  sample_delay;
  logic [7:0]  strobe_width;
  logic [7:0]  rate_codes;

  logic [17:0] period_count, period_count_next;
  logic [2:0]  beat_phase, beat_phase_next;
  logic [9:0]  pulse_count, pulse_count_next;
  logic        line_prev;
  logic [7:0]  beat_count, beat_count_next;
  logic [3:0]  pending_mask, pending_mask_next;
  logic [3:0]  strobe_mask, strobe_mask_next;
  logic [7:0]  strobe_count, strobe_count_next;
  logic [7:0]  sample_count, sample_count_next;

  logic [18:0] period_inc;
  logic [9:0]  pulse_mid;
  logic [7:0]  sample_mid;
  logic [7:0]  beat_mid;
  logic [7:0]  strobe_mid;
  logic        edge_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_period  <= BEAT_PERIOD_RESET;
      short_width  <= SHORT_WIDTH_RESET;
      long_width   <= LONG_WIDTH_RESET;
      sample_delay <= SAMPLE_DELAY_RESET;
      strobe_width <= STROBE_WIDTH_RESET;
      rate_codes   <= RATE_CODES_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BEAT_PERIOD:  beat_period  <= cfg_data;
        REG_SHORT_WIDTH:  short_width  <= cfg_data[9:0];
        REG_LONG_WIDTH:   long_width   <= cfg_data[9:0];
        REG_SAMPLE_DELAY: sample_delay <= cfg_data[7:0];
        REG_STROBE_WIDTH: strobe_width <= cfg_data[7:0];
        REG_RATE_CODES:   rate_codes   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    period_inc = {1'b0, period_count} + 19'd1;
    beat_phase_next = beat_phase;
    pulse_mid = pulse_count;
    if (period_inc >= {1'b0, beat_period}) begin
      period_count_next = '0;
      beat_phase_next = beat_phase + 3'd1;
      pulse_mid = (beat_phase_next == 3'd0) ? long_width : short_width;
    end else begin
      period_count_next = period_inc[17:0];
    end
    result.trigger_pulse = (pulse_mid != 10'd0);
    pulse_count_next = result.trigger_pulse ? pulse_mid - 10'd1 : 10'd0;

    // A line still high when the sample countdown expires marks the sync beat.
    sample_mid = sample_count;
    beat_mid = beat_count;
    if (sample_count != 8'd0) begin
      sample_mid = sample_count - 8'd1;
      if (sample_mid == 8'd0 && trig_line) begin
        beat_mid = 8'd0;
      end
    end

    edge_ok = trig_line && !line_prev && (strobe_count == 8'd0);
    strobe_mask_next = strobe_mask;
    strobe_mid = strobe_count;
    beat_count_next = beat_mid;
    pending_mask_next = pending_mask;
    sample_count_next = sample_mid;
    if (edge_ok) begin
      strobe_mask_next = pending_mask;
      strobe_mid = strobe_width;
      beat_count_next = beat_mid + 8'd1;
      pending_mask_next = next_mask(beat_count_next, rate_codes);
      sample_count_next = sample_delay;
    end

    result.camera_strobes = (strobe_mid != 8'd0) ? strobe_mask_next : 4'd0;
    strobe_count_next = (strobe_mid != 8'd0) ? strobe_mid - 8'd1 : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      period_count <= '0;
      beat_phase   <= '0;
      pulse_count  <= '0;
      line_prev    <= 1'b0;
      beat_count   <= '0;
      pending_mask <= '0;
      strobe_mask  <= '0;
      strobe_count <= '0;
      sample_count <= '0;
    end else if (tick) begin
      period_count <= period_count_next;
      beat_phase   <= beat_phase_next;
      pulse_count  <= pulse_count_next;
      line_prev    <= trig_line;
      beat_count   <= beat_count_next;
      pending_mask <= pending_mask_next;
      strobe_mask  <= strobe_mask_next;
      strobe_count <= strobe_count_next;
      sample_count <= sample_count_next;
    end
  end

endmodule

>>> sv/sts_outbuf.sv
// Two-entry output buffer that holds results until the sink takes them.
module sts_outbuf (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  sts_pkg::result_t push_data,
  output logic             space,
  output logic             out_valid,
  input  logic             out_ready,
  output sts_pkg::result_t out_data
);
  import sts_pkg::*;

  result_t    slot0, slot1;
  logic [1:0] count, count_next;
  logic       pop;

  assign pop = out_valid && out_ready;
  assign space = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data = slot0;

  always_comb begin
    count_next = count;
    priority if (push && !pop) begin
      count_next = count + 2'd1;
    end else if (pop && !push) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      slot0 <= (count == 2'd2) ? slot1 : push_data;
    end else if (push && count == 2'd0) begin
      slot0 <= push_data;
    end
    if (push && ((count == 2'd1 && !pop) || (count == 2'd2 && pop))) begin
      slot1 <= push_data;
    end
  end

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("output buffer count out of range");
  a_push_fits: assert property (@(posedge clk) disable iff (rst)
    push |-> space)
    else $error("transfer into a full output buffer");
  a_push_shows: assert property (@(posedge clk) disable iff (rst)
    push |=> out_valid)
    else $error("accepted tick produced no result");
  a_hold_full: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd2 && !pop) |=> (count == 2'd2 && !space))
    else $error("full buffer lost an entry");
`endif

endmodule

>>> dv/tb_sync_trigger_strobe_timer.sv
`timescale 1ns / 1ps
// Testbench of the synchronized trigger generator and camera strobe timer.
module tb_sync_trigger_strobe_timer;
  import sts_pkg::*;

  typedef enum logic [1:0] {LINE_LOW, LINE_HIGH, LINE_ECHO} line_src_t;

  localparam int CYCLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  sts_in_if item ();
  sts_out_if result ();

  sync_trigger_strobe_timer DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .item(item),
    .result(result)
  );

  always #2 clk = ~clk;

  logic [17:0] cfg_beat_period;
  logic [9:0] cfg_short_width;
  logic [9:0] cfg_long_width;
  logic [7:0] cfg_sample_delay;
  logic [7:0] cfg_strobe_width;
  logic [7:0] cfg_rate_codes;

  logic [17:0] period_cnt;
  logic [2:0] beat_phase;
  logic [9:0] pulse_cnt;
  logic line_prev;
  logic [7:0] beat_cnt;
  logic [3:0] pending_mask;
  logic [3:0] strobe_mask;
  logic [7:0] strobe_cnt;
  logic [7:0] sample_cnt;

  line_src_t line_q[$];
  result_t pending_results[$];
  int errors = 0;
  int cycles = 0;
  int send_gap = 0;
  int drain_gap = 0;
  bit quiet = 1'b0;
  logic tick_taken;

  task automatic clear_timer();
    cfg_beat_period = BEAT_PERIOD_RESET;
    cfg_short_width = SHORT_WIDTH_RESET;
    cfg_long_width = LONG_WIDTH_RESET;
    cfg_sample_delay = SAMPLE_DELAY_RESET;
    cfg_strobe_width = STROBE_WIDTH_RESET;
    cfg_rate_codes = RATE_CODES_RESET;
    period_cnt = '0;
    beat_phase = '0;
    pulse_cnt = '0;
    line_prev = 1'b0;
    beat_cnt = '0;
    pending_mask = '0;
    strobe_mask = '0;
    strobe_cnt = '0;
    sample_cnt = '0;
  endtask

  function automatic logic [3:0] beat_fire_mask(input logic [7:0] beats);
    logic [3:0] m;
    int span;
    m = '0;
    for (int i = 0; i < 4; i++) begin
      span = 8 >> cfg_rate_codes[2*i +: 2];
      if ((int'(beats) % span) == 0) begin
        m[i] = 1'b1;
      end
    end
    return m;
  endfunction

  // Level the generator will drive on the next tick, for loopback traffic.
  function automatic logic echo_level();
    logic [2:0] ph;
    if (int'(period_cnt) + 1 >= int'(cfg_beat_period)) begin
      ph = beat_phase + 3'd1;
      return (ph == 3'd0) ? (cfg_long_width != '0) : (cfg_short_width != '0);
    end
    return pulse_cnt != '0;
  endfunction

  task automatic timer_tick(input logic line);
    result_t r;
    if (int'(period_cnt) + 1 >= int'(cfg_beat_period)) begin
      period_cnt = '0;
      beat_phase = beat_phase + 3'd1;
      pulse_cnt = (beat_phase == 3'd0) ? cfg_long_width : cfg_short_width;
    end else begin
      period_cnt = period_cnt + 18'd1;
    end
    r.trigger_pulse = (pulse_cnt != '0);
    if (pulse_cnt != '0) begin
      pulse_cnt = pulse_cnt - 10'd1;
    end
    if (sample_cnt != '0) begin
      sample_cnt = sample_cnt - 8'd1;
      if (sample_cnt == '0 && line) begin
        beat_cnt = '0;
      end
    end
    if (line && !line_prev && strobe_cnt == '0) begin
      strobe_mask = pending_mask;
      strobe_cnt = cfg_strobe_width;
      beat_cnt = beat_cnt + 8'd1;
      pending_mask = beat_fire_mask(beat_cnt);
      sample_cnt = cfg_sample_delay;
    end
    line_prev = line;
    r.camera_strobes = (strobe_cnt != '0) ? strobe_mask : 4'd0;
    if (strobe_cnt != '0) begin
      strobe_cnt = strobe_cnt - 8'd1;
    end
    pending_results.push_back(r);
  endtask

  task automatic push_level(input line_src_t src, input int n);
    repeat (n) line_q.push_back(src);
  endtask

  // Mostly trigger pulses of random shape, plus loopback runs, noise and glitches.
  task automatic add_traffic(input int n);
    int added;
    int kind;
    int hi;
    int lo;
    int m;
    added = 0;
    while (added < n) begin
      kind = $urandom_range(0, 9);
      if (kind <= 5) begin
        if ($urandom_range(0, 2) == 0) begin
          hi = int'(cfg_sample_delay) + $urandom_range(1, 3);
        end else begin
          hi = $urandom_range(1, int'(cfg_sample_delay) + 1);
        end
        lo = $urandom_range(1, int'(cfg_strobe_width) + 4);
        push_level(LINE_HIGH, hi);
        push_level(LINE_LOW, lo);
        added += hi + lo;
      end else if (kind <= 7) begin
        m = $urandom_range(10, 80);
        push_level(LINE_ECHO, m);
        added += m;
      end else if (kind == 8) begin
        m = $urandom_range(1, 12);
        repeat (m) push_level($urandom_range(0, 1) ? LINE_HIGH : LINE_LOW, 1);
        added += m;
      end else begin
        push_level(LINE_HIGH, 1);
        push_level(LINE_LOW, 1);
        added += 2;
      end
    end
  endtask

  task automatic wait_idle();
    while (line_q.size() != 0 || item.valid || pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input int unsigned val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_DATA_BITS-1:0];
    @(posedge clk);
    case (idx)
      REG_BEAT_PERIOD: cfg_beat_period = val[17:0];
      REG_SHORT_WIDTH: cfg_short_width = val[9:0];
      REG_LONG_WIDTH: cfg_long_width = val[9:0];
      REG_SAMPLE_DELAY: cfg_sample_delay = val[7:0];
      REG_STROBE_WIDTH: cfg_strobe_width = val[7:0];
      REG_RATE_CODES: cfg_rate_codes = val[7:0];
      default: ;
    endcase
  endtask

  task automatic load_config(input int unsigned period, input int unsigned short_w,
                             input int unsigned long_w, input int unsigned delay,
                             input int unsigned strobe_w, input int unsigned codes);
    wait_idle();
    write_reg(REG_BEAT_PERIOD, period);
    write_reg(REG_SHORT_WIDTH, short_w);
    write_reg(REG_LONG_WIDTH, long_w);
    write_reg(REG_SAMPLE_DELAY, delay);
    write_reg(REG_STROBE_WIDTH, strobe_w);
    write_reg(REG_RATE_CODES, codes);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  always @(negedge clk) begin : drive_ticks
    line_src_t src;
    logic lvl;
    if (rst) begin
      item.valid <= 1'b0;
    end else if (!item.valid || tick_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        item.valid <= 1'b0;
      end else if (line_q.size() == 0) begin
        item.valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        send_gap = $urandom_range(0, 8);
        item.valid <= 1'b0;
      end else begin
        src = line_q.pop_front();
        case (src)
          LINE_HIGH: lvl = 1'b1;
          LINE_ECHO: lvl = echo_level();
          default: lvl = 1'b0;
        endcase
        item.valid <= 1'b1;
        item.trig_line <= lvl;
      end
    end
  end

  always @(negedge clk) begin : drive_ready
    if (rst) begin
      result.ready <= 1'b0;
    end else if (drain_gap > 0) begin
      drain_gap--;
      result.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      drain_gap = $urandom_range(0, 8);
      result.ready <= 1'b0;
    end else begin
      result.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_ticks
    result_t want;
    if (rst) begin
      tick_taken <= 1'b0;
    end else begin
      tick_taken <= item.valid && item.ready;
      if (item.valid && item.ready) begin
        timer_tick(item.trig_line);
      end
      if (result.valid && result.ready) begin
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected transfer, expected none, actual pulse %0b strobes %h",
                   $time, result.trigger_pulse, result.camera_strobes);
        end else begin
          want = pending_results.pop_front();
          if (result.trigger_pulse !== want.trigger_pulse) begin
            errors++;
            $display("%0t: trigger_pulse expected %0b actual %0b",
                     $time, want.trigger_pulse, result.trigger_pulse);
          end
          if (result.camera_strobes !== want.camera_strobes) begin
            errors++;
            $display("%0t: camera_strobes expected %h actual %h",
                     $time, want.camera_strobes, result.camera_strobes);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    item.valid = 1'b0;
    item.trig_line = 1'b0;
    result.ready = 1'b0;
    clear_timer();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: a sync-length pulse, then an edge inside the strobe.
    push_level(LINE_LOW, 2);
    push_level(LINE_HIGH, 18);
    push_level(LINE_LOW, 3);
    push_level(LINE_HIGH, 2);
    push_level(LINE_LOW, 1);

    // Every rate code at once, short edges that walk the beat count, then a sync.
    load_config(3, 1, 2, 2, 2, 8'b11_10_01_00);
    repeat (9) begin
      push_level(LINE_HIGH, 1);
      push_level(LINE_LOW, 2);
    end
    push_level(LINE_HIGH, 3);
    push_level(LINE_LOW, 2);

    // All widths and delays zero: nothing is blocked and no sync sample is taken.
    load_config(0, 0, 0, 0, 0, 0);
    push_level(LINE_HIGH, 1);
    push_level(LINE_LOW, 1);
    push_level(LINE_HIGH, 2);
    push_level(LINE_LOW, 1);
    push_level(LINE_ECHO, 4);

    load_config(18'h3FFFF, 10'h3FF, 10'h3FF, 8'hFF, 8'hFF, 8'hFF);
    add_traffic(300);

    for (int phase = 0; phase < 9; phase++) begin
      if (phase == 4) begin
        load_config(1, 10'h3FF, 1, 1, 1, 8'h00);
      end else begin
        load_config($urandom_range(0, 6) == 0 ? $urandom_range(0, 18'h3FFFF)
                                             : $urandom_range(1, 40),
                    $urandom_range(0, 12), $urandom_range(0, 40),
                    $urandom_range(0, 20), $urandom_range(0, 30),
                    $urandom_range(0, 255));
      end
      if (phase == 8) begin
        quiet = 1'b1;
      end
      add_traffic(100);
    end

    wait_idle();
    repeat (5) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
